// ----- rtl/usb_endpoint_slot_allocator_defines.svh -----
// Assertion macros for the endpoint slot allocator.
`ifndef USB_ENDPOINT_SLOT_ALLOCATOR_DEFINES_SVH
`define USB_ENDPOINT_SLOT_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define USBESA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define USBESA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define USBESA_ASSERT(lbl, prop, msg)
`define USBESA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/usbesa_pkg.sv -----
`timescale 1ns / 1ps
package usbesa_pkg;
	localparam int SLOTS            = 8;
	localparam int PACKET_MEM_BYTES = 2048;
	localparam int SLOT_W           = $clog2(SLOTS);
	localparam int ADDR_W           = $clog2(PACKET_MEM_BYTES + 1);
	localparam int SUM_W            = ADDR_W + 2;
	localparam int DESC_BYTES       = 8 * SLOTS;

	localparam logic [6:0] EP0_BYTES_RESET = 7'd64;

	localparam logic [1:0] OP_ALLOC     = 2'd0;
	localparam logic [1:0] OP_BUS_RESET = 2'd1;
	localparam logic [1:0] OP_CLOSE_ALL = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_SLOT = 2'd1;
	localparam logic [1:0] STAT_NO_MEM  = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	typedef struct packed {
		logic [3:0] num;
		logic       dir_in;
		logic [1:0] kind;
		logic       mem_ok;
	} req_t;

	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [SLOT_W-1:0] idx;
	} tok_t;

	typedef struct packed {
		logic clr;
		logic ep0;
	} cmd_t;

	function automatic logic [2:0] to_slot3(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+2:0] wide;
		wide = {3'b000, s};
		return wide[2:0];
	endfunction

	function automatic logic [10:0] to_addr11(input logic [ADDR_W-1:0] a);
		logic [ADDR_W+10:0] wide;
		wide = {11'd0, a};
		return wide[10:0];
	endfunction
endpackage

// ----- rtl/usb_endpoint_slot_allocator.sv -----
`timescale 1ns / 1ps
// Channel     | Handshake            | Payload
// ------------+----------------------+---------------------------------------------
// request     | start, busy          | op, ep_number, ep_direction, ep_kind,
//             |                      | buffer_bytes
// result      | done (one cycle)     | slot_index, buffer_addr, status
// config      | cfg_wr_en            | cfg_wr_data (ep0 packet bytes)
//
// An allocate transfer walks the slot cells one per cycle through a launch
// register and each cell's register; busy stays high until the result strobes.
// Bus reset, close-all and the unused op strobe their result in the next cycle
// and a new transfer can be accepted every cycle.
// Reset leaves every slot unused and the pointer just past the descriptor table.
// The receiver cannot stall; results are never held back.
`include "usb_endpoint_slot_allocator_defines.svh"
module usb_endpoint_slot_allocator import usbesa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [3:0]  ep_number,
	input  logic        ep_direction,
	input  logic [1:0]  ep_kind,
	input  logic [10:0] buffer_bytes,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	output logic        done,
	output logic [2:0]  slot_index,
	output logic [10:0] buffer_addr,
	output logic [1:0]  status
);
	state_t            state_q;
	state_t            state_d;
	logic [6:0]        ep0_bytes_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] nxt_ptr_q;
	req_t              req_q;
	logic              launch_q;
	logic              done_q;
	logic [2:0]        slot_q;
	logic [10:0]       addr_q;
	logic [1:0]        status_q;

	logic              accept;
	logic [SUM_W-1:0]  sum;
	logic [ADDR_W-1:0] base;
	tok_t              chain [SLOTS+1];
	tok_t              tail;
	cmd_t              cmds [SLOTS];

	assign accept = start && !busy;
	assign sum    = SUM_W'(ptr_q) + SUM_W'(buffer_bytes);
	assign base   = ADDR_W'(DESC_BYTES) + ADDR_W'({ep0_bytes_q, 1'b0});
	assign tail   = chain[SLOTS];

	assign chain[0] = '{valid: launch_q, hit: 1'b0, idx: '0};

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			cmds[i].clr = accept && ((op == OP_BUS_RESET) || ((op == OP_CLOSE_ALL) && (i != 0)));
			cmds[i].ep0 = accept && (op == OP_BUS_RESET) && (i == 0);
		end
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		usbesa_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.req     (req_q),
			.cmd     (cmds[g]),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_ALLOC)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (tail.valid) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ep0_bytes_q <= EP0_BYTES_RESET;
			ptr_q       <= ADDR_W'(DESC_BYTES);
			launch_q    <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept && (op == OP_ALLOC);
			done_q   <= (accept && (op != OP_ALLOC)) || tail.valid;
			if (cfg_wr_en) begin
				ep0_bytes_q <= cfg_wr_data;
			end
			if (accept && ((op == OP_BUS_RESET) || (op == OP_CLOSE_ALL))) begin
				ptr_q <= base;
			end else if (tail.valid && tail.hit && req_q.mem_ok) begin
				ptr_q <= nxt_ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (op == OP_ALLOC)) begin
			req_q.num    <= ep_number;
			req_q.dir_in <= ep_direction;
			req_q.kind   <= ep_kind;
			req_q.mem_ok <= (sum <= SUM_W'(PACKET_MEM_BYTES));
			nxt_ptr_q    <= sum[ADDR_W-1:0];
		end
		if (accept && (op != OP_ALLOC)) begin
			slot_q   <= 3'd0;
			status_q <= STAT_OK;
			case (op)
				OP_BUS_RESET, OP_CLOSE_ALL: addr_q <= to_addr11(base);
				default:                    addr_q <= 11'd0;
			endcase
		end else if (tail.valid) begin
			if (!tail.hit) begin
				slot_q   <= 3'd0;
				addr_q   <= 11'd0;
				status_q <= STAT_NO_SLOT;
			end else if (!req_q.mem_ok) begin
				slot_q   <= 3'd0;
				addr_q   <= 11'd0;
				status_q <= STAT_NO_MEM;
			end else begin
				slot_q   <= to_slot3(tail.idx);
				addr_q   <= to_addr11(ptr_q);
				status_q <= STAT_OK;
			end
		end
	end

	assign done        = done_q;
	assign slot_index  = slot_q;
	assign buffer_addr = addr_q;
	assign status      = status_q;

	`USBESA_ASSERT(a_tail_done, tail.valid |=> (done && !busy), "search end gave no result")
	`USBESA_ASSERT(a_alloc_busy, (start && !busy && (op == OP_ALLOC)) |=> busy, "allocate did not start a search")
	`USBESA_ASSERT(a_cmd_done, (start && !busy && (op != OP_ALLOC)) |=> done, "command gave no result")
	`USBESA_ASSERT(a_tail_search, tail.valid |-> (state_q == ST_SEARCH), "token left the chain outside a search")
	`USBESA_ASSERT_ALWAYS(a_fail_zero, (done && (status != STAT_OK)) |-> ((slot_index == 3'd0) && (buffer_addr == 11'd0)), "failed transfer carries a slot or address")
endmodule

// ----- rtl/usbesa_cell.sv -----
`timescale 1ns / 1ps
module usbesa_cell import usbesa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	input  tok_t tok_in,
	output tok_t tok_out
);
	logic       used_q;
	logic [3:0] num_q;
	logic [1:0] kind_q;
	logic       out_q;
	logic       in_q;
	tok_t       tok_q;

	logic taken;
	logic same;
	logic hold;
	logic claim;
	logic live;

	always_comb begin
		taken = req.dir_in ? in_q : out_q;
		same  = used_q && (num_q == req.num) && (kind_q == req.kind);
		hold  = taken && same;
		claim = !taken && (!used_q || same);
		live  = tok_in.valid && !tok_in.hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			num_q  <= '0;
			kind_q <= '0;
			out_q  <= 1'b0;
			in_q   <= 1'b0;
		end else if (cmd.ep0) begin
			used_q <= 1'b1;
			num_q  <= '0;
			kind_q <= '0;
			out_q  <= 1'b1;
			in_q   <= 1'b1;
		end else if (cmd.clr) begin
			used_q <= 1'b0;
			num_q  <= '0;
			kind_q <= '0;
			out_q  <= 1'b0;
			in_q   <= 1'b0;
		end else if (live && claim && req.mem_ok) begin
			used_q <= 1'b1;
			num_q  <= req.num;
			kind_q <= req.kind;
			if (req.dir_in) begin
				in_q <= 1'b1;
			end else begin
				out_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.hit   <= tok_in.hit || (live && (hold || claim));
			if (tok_in.hit || hold || claim) begin
				tok_q.idx <= tok_in.idx;
			end else begin
				tok_q.idx <= tok_in.idx + SLOT_W'(1);
			end
		end
	end

	assign tok_out = tok_q;
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb import usbesa_pkg::*; ;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_XFERS = 250;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  num;
		logic        dir;
		logic [1:0]  kind;
		logic [10:0] bytes;
	} xfer_t;

	typedef struct packed {
		logic [2:0]  slot;
		logic [10:0] addr;
		logic [1:0]  stat;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = '0;
	logic [3:0]  ep_number = '0;
	logic        ep_direction = 1'b0;
	logic [1:0]  ep_kind = '0;
	logic [10:0] buffer_bytes = '0;
	logic        cfg_wr_en = 1'b0;
	logic [6:0]  cfg_wr_data = '0;
	logic        done;
	logic [2:0]  slot_index;
	logic [10:0] buffer_addr;
	logic [1:0]  status;

	xfer_t  req_q[$];
	grant_t grant_q[$];
	int     sent_cnt = 0;
	int     took_cnt = 0;
	int     idle_pct = 0;
	int     n_bad = 0;
	int     n_ok = 0;
	int     n_no_slot = 0;
	int     n_no_mem = 0;
	int     n_cfg = 0;
	int     cyc = 0;

	logic       slot_live [SLOTS] = '{default: 1'b0};
	logic [3:0] slot_num [SLOTS] = '{default: 4'd0};
	logic [1:0] slot_kind [SLOTS] = '{default: 2'd0};
	logic       slot_out [SLOTS] = '{default: 1'b0};
	logic       slot_in [SLOTS] = '{default: 1'b0};
	int         free_ptr = DESC_BYTES;
	logic [6:0] ep0_bytes = EP0_BYTES_RESET;

	usb_endpoint_slot_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.ep_number(ep_number),
		.ep_direction(ep_direction),
		.ep_kind(ep_kind),
		.buffer_bytes(buffer_bytes),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done(done),
		.slot_index(slot_index),
		.buffer_addr(buffer_addr),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT_CYCLES) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic drop_slots(input int lo);
		int s;
		for (s = lo; s < SLOTS; s++) begin
			slot_live[s] = 1'b0;
			slot_num[s] = '0;
			slot_kind[s] = '0;
			slot_out[s] = 1'b0;
			slot_in[s] = 1'b0;
		end
	endtask

	task automatic predict_grant(input xfer_t x);
		grant_t g;
		logic   held;
		logic   same;
		logic   found;
		logic   claim;
		int     s;
		int     pick;
		g = '0;
		found = 1'b0;
		claim = 1'b0;
		pick = 0;
		case (x.op)
			OP_ALLOC: begin
				for (s = 0; s < SLOTS && !found; s++) begin
					held = x.dir ? slot_in[s] : slot_out[s];
					same = slot_live[s] && slot_num[s] == x.num && slot_kind[s] == x.kind;
					if (held && same) begin
						found = 1'b1;
						pick = s;
					end else if (!held && (!slot_live[s] || same)) begin
						found = 1'b1;
						claim = 1'b1;
						pick = s;
					end
				end
				if (!found) begin
					g.stat = STAT_NO_SLOT;
				end else if (free_ptr + int'(x.bytes) > PACKET_MEM_BYTES) begin
					g.stat = STAT_NO_MEM;
				end else begin
					if (claim) begin
						slot_live[pick] = 1'b1;
						slot_num[pick] = x.num;
						slot_kind[pick] = x.kind;
						if (x.dir)
							slot_in[pick] = 1'b1;
						else
							slot_out[pick] = 1'b1;
					end
					g.slot = pick[2:0];
					g.addr = free_ptr[10:0];
					free_ptr = free_ptr + int'(x.bytes);
				end
			end
			OP_BUS_RESET: begin
				drop_slots(0);
				slot_live[0] = 1'b1;
				slot_out[0] = 1'b1;
				slot_in[0] = 1'b1;
				free_ptr = DESC_BYTES + 2 * int'(ep0_bytes);
				g.addr = free_ptr[10:0];
			end
			OP_CLOSE_ALL: begin
				drop_slots(1);
				free_ptr = DESC_BYTES + 2 * int'(ep0_bytes);
				g.addr = free_ptr[10:0];
			end
			default: begin
			end
		endcase
		case (g.stat)
			STAT_OK:      n_ok++;
			STAT_NO_SLOT: n_no_slot++;
			default:      n_no_mem++;
		endcase
		grant_q.push_back(g);
	endtask

	always @(negedge clk) begin : drive_proc
		xfer_t x;
		logic  nxt_start;
		nxt_start = start;
		if (arst_n && sent_cnt == took_cnt) begin
			nxt_start = 1'b0;
			if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
				x = req_q.pop_front();
				op <= x.op;
				ep_number <= x.num;
				ep_direction <= x.dir;
				ep_kind <= x.kind;
				buffer_bytes <= x.bytes;
				nxt_start = 1'b1;
				sent_cnt <= sent_cnt + 1;
			end
		end
		start <= nxt_start;
	end

	always @(posedge clk) begin : watch_proc
		grant_t want;
		grant_t got;
		xfer_t  x;
		if (arst_n) begin
			if (done) begin
				got.slot = slot_index;
				got.addr = buffer_addr;
				got.stat = status;
				if (grant_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected result: slot %0d addr %0d status %0d",
							got.slot, got.addr, got.stat);
				end else begin
					want = grant_q.pop_front();
					if (want.slot !== got.slot || want.addr !== got.addr ||
						want.stat !== got.stat) begin
						n_bad++;
						if (n_bad <= 10)
							$display("mismatch: slot %0d/%0d addr %0d/%0d status %0d/%0d (exp/act)",
								want.slot, got.slot, want.addr, got.addr, want.stat, got.stat);
					end
				end
			end
			if (cfg_wr_en)
				ep0_bytes = cfg_wr_data;
			if (start && !busy) begin
				x.op = op;
				x.num = ep_number;
				x.dir = ep_direction;
				x.kind = ep_kind;
				x.bytes = buffer_bytes;
				predict_grant(x);
				took_cnt <= took_cnt + 1;
			end
		end
	end

	task automatic push_xfer(input logic [1:0] o, input logic [3:0] n, input logic d,
		input logic [1:0] k, input logic [10:0] b);
		xfer_t x;
		x.op = o;
		x.num = n;
		x.dir = d;
		x.kind = k;
		x.bytes = b;
		req_q.push_back(x);
	endtask

	task automatic push_random;
		int r;
		int rb;
		logic [10:0] b;
		r = $urandom_range(99);
		rb = $urandom_range(99);
		if (rb < 70)
			b = 11'(4 * $urandom_range(16));
		else if (rb < 85)
			b = 11'($urandom_range(300));
		else if (rb < 95)
			b = 11'(4 * $urandom_range(256));
		else
			b = 11'($urandom_range(2047));
		if (r < 5)
			push_xfer(OP_BUS_RESET, 4'($urandom), 1'($urandom), 2'($urandom), 11'($urandom));
		else if (r < 9)
			push_xfer(OP_CLOSE_ALL, 4'($urandom), 1'($urandom), 2'($urandom), 11'($urandom));
		else if (r < 11)
			push_xfer(OP_SPARE, 4'($urandom), 1'($urandom), 2'($urandom), 11'($urandom));
		else
			push_xfer(OP_ALLOC, ($urandom_range(99) < 80) ? 4'($urandom_range(5)) : 4'($urandom),
				1'($urandom), 2'($urandom), b);
	endtask

	task automatic drain;
		while (req_q.size() > 0 || sent_cnt != took_cnt || grant_q.size() > 0)
			@(posedge clk);
		repeat (SLOTS + 4) @(posedge clk);
	endtask

	task automatic set_ep0_bytes(input logic [6:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		n_cfg++;
	endtask

	initial begin : run_proc
		logic [6:0] sizes [6];
		int         idles [6];
		int         p;
		int         i;
		sizes = '{7'd8, 7'd127, 7'd0, 7'd64, 7'($urandom_range(8, 64)), 7'd1};
		idles = '{0, 75, 0, 25, 75, 25};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Endpoint 0 is not set up until the first bus reset.
		push_xfer(OP_ALLOC, 4'd1, 1'b0, 2'd2, 11'd64);
		push_xfer(OP_SPARE, 4'd15, 1'b1, 2'd3, 11'd2047);
		push_xfer(OP_BUS_RESET, 4'd0, 1'b0, 2'd0, 11'd0);
		push_xfer(OP_ALLOC, 4'd0, 1'b1, 2'd0, 11'd0);
		push_xfer(OP_ALLOC, 4'd1, 1'b1, 2'd2, 11'd3);
		push_xfer(OP_ALLOC, 4'd1, 1'b0, 2'd2, 11'd4);
		push_xfer(OP_ALLOC, 4'd1, 1'b0, 2'd3, 11'd8);
		push_xfer(OP_ALLOC, 4'd15, 1'b1, 2'd1, 11'd1024);
		push_xfer(OP_ALLOC, 4'd9, 1'b0, 2'd2, 11'd2047);
		for (i = 2; i < 6; i++)
			push_xfer(OP_ALLOC, 4'(i), 1'b0, 2'd2, 11'd0);
		push_xfer(OP_ALLOC, 4'd6, 1'b0, 2'd2, 11'd4);
		push_xfer(OP_ALLOC, 4'd2, 1'b0, 2'd2, 11'd16);
		push_xfer(OP_ALLOC, 4'd3, 1'b1, 2'd2, 11'd500);
		push_xfer(OP_ALLOC, 4'd4, 1'b1, 2'd2, 11'd0);
		push_xfer(OP_CLOSE_ALL, 4'd15, 1'b1, 2'd3, 11'd2047);
		push_xfer(OP_ALLOC, 4'd7, 1'b0, 2'd2, 11'd1024);
		push_xfer(OP_ALLOC, 4'd7, 1'b1, 2'd2, 11'd1024);
		push_xfer(OP_BUS_RESET, 4'd15, 1'b1, 2'd3, 11'd2047);
		push_xfer(OP_CLOSE_ALL, 4'd0, 1'b0, 2'd0, 11'd0);

		for (p = 0; p < 6; p++) begin
			set_ep0_bytes(sizes[p]);
			idle_pct = idles[p];
			push_xfer(OP_BUS_RESET, 4'd0, 1'b0, 2'd0, 11'd0);
			for (i = 0; i < PHASE_XFERS; i++)
				push_random();
		end
		drain();

		$display("%0d transfers checked: %0d granted, %0d without a slot, %0d out of memory",
			took_cnt, n_ok, n_no_slot, n_no_mem);
		$display("endpoint 0 buffer size rewritten %0d times, sender idle up to 75 percent",
			n_cfg);
		if (n_bad == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/usbesa_pkg.sv
rtl/usbesa_cell.sv
rtl/usb_endpoint_slot_allocator.sv
tb/tb.sv
